/* design/nplc_pkg.sv */
// Shared types and constants for the nearest palette color lookup block.
// Used by nplc_seq, nplc_dist and nearest_palette_color_lookup_top.
package nplc_pkg;

    localparam int IDX_W       = 8;   // palette index width (up to 256 entries)
    localparam int CH_W        = 8;   // one color channel
    localparam int C5_W        = 5;   // one channel of a 15-bit color
    localparam int COLOR15_W   = 15;
    localparam int RGB_W       = 24;
    localparam int WORD_W      = 32;
    localparam int SQ_W        = 16;  // square of one channel difference
    localparam int DIST_W      = 18;  // sum of three squares, at most 195075
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [CH_W-1:0] ALPHA_CLEAR  = 8'h00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // Marks one palette read on its way through the distance pipeline.
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_tag;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] distance;
    } t_dist;

    // A 5-bit channel c becomes c*8+4.
    function automatic logic [CH_W-1:0] expand5(input logic [C5_W-1:0] c);
        return {c, 3'b100};
    endfunction

endpackage

/* design/nplc_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies; used for the palette store.
module nplc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/nplc_dist.sv */
// Shared squared-distance unit: one palette entry per cycle, two register stages.
// Depends on nplc_pkg; its tag input lines up with the RAM read issued in the same cycle.
module nplc_dist (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  nplc_pkg::t_tag           i_tag,
    input  logic [nplc_pkg::RGB_W-1:0] i_entry,
    input  logic [nplc_pkg::CH_W-1:0]  i_tr,
    input  logic [nplc_pkg::CH_W-1:0]  i_tg,
    input  logic [nplc_pkg::CH_W-1:0]  i_tb,
    output nplc_pkg::t_dist          o_res
);
    import nplc_pkg::*;

    t_tag            r_tag1;
    t_tag            r_tag2;
    logic [SQ_W-1:0] r_sq_r;
    logic [SQ_W-1:0] r_sq_g;
    logic [SQ_W-1:0] r_sq_b;
    t_dist           r_res;

    logic [CH_W-1:0] w_dr;
    logic [CH_W-1:0] w_dg;
    logic [CH_W-1:0] w_db;

    function automatic logic [CH_W-1:0] absdiff(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    assign w_dr = absdiff(i_tr, i_entry[CH_W-1:0]);
    assign w_dg = absdiff(i_tg, i_entry[2*CH_W-1:CH_W]);
    assign w_db = absdiff(i_tb, i_entry[3*CH_W-1:2*CH_W]);

    // Stage 1 squares the channel differences, stage 2 adds them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1.valid <= 1'b0;
            r_tag2.valid <= 1'b0;
            r_res.valid  <= 1'b0;
        end else begin
            r_tag1.valid <= i_tag.valid;
            r_tag2.valid <= r_tag1.valid;
            r_res.valid  <= r_tag2.valid;
        end
        r_tag1.last    <= i_tag.last;
        r_tag1.idx     <= i_tag.idx;
        r_tag2.last    <= r_tag1.last;
        r_tag2.idx     <= r_tag1.idx;
        r_sq_r         <= SQ_W'(w_dr) * SQ_W'(w_dr);
        r_sq_g         <= SQ_W'(w_dg) * SQ_W'(w_dg);
        r_sq_b         <= SQ_W'(w_db) * SQ_W'(w_db);
        r_res.last     <= r_tag2.last;
        r_res.idx      <= r_tag2.idx;
        r_res.distance <= DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b);
    end

    assign o_res = r_res;

endmodule

/* design/nplc_seq.sv */
// Sequencer: accepts words, writes the palette, sweeps it for lookups, keeps the best match
// and holds the output register. Depends on nplc_pkg.
module nplc_seq #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_cmd,
    input  logic [nplc_pkg::IDX_W-1:0]         i_entry_index,
    input  logic [nplc_pkg::CH_W-1:0]          i_red,
    input  logic [nplc_pkg::CH_W-1:0]          i_green,
    input  logic [nplc_pkg::CH_W-1:0]          i_blue,
    input  logic [nplc_pkg::COLOR15_W-1:0]     i_color15,
    output logic                               o_ram_we,
    output logic                               o_ram_re,
    output logic [$clog2(PALETTE_ENTRIES)-1:0] o_ram_addr,
    output logic [nplc_pkg::RGB_W-1:0]         o_ram_wdata,
    output nplc_pkg::t_tag                     o_tag,
    output logic [nplc_pkg::CH_W-1:0]          o_tr,
    output logic [nplc_pkg::CH_W-1:0]          o_tg,
    output logic [nplc_pkg::CH_W-1:0]          o_tb,
    input  nplc_pkg::t_dist                    i_dist,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_out_kind,
    output logic [nplc_pkg::IDX_W-1:0]         o_out_index,
    output logic [nplc_pkg::WORD_W-1:0]        o_out_word
);
    import nplc_pkg::*;

    localparam int AW = $clog2(PALETTE_ENTRIES);

    t_state            r_state,     n_state;
    logic [AW-1:0]     r_addr,      n_addr;
    logic [CH_W-1:0]   r_tr,        n_tr;
    logic [CH_W-1:0]   r_tg,        n_tg;
    logic [CH_W-1:0]   r_tb,        n_tb;
    logic [DIST_W-1:0] r_best_dist, n_best_dist;
    logic [IDX_W-1:0]  r_best_idx,  n_best_idx;
    logic              r_res_kind,  n_res_kind;
    logic [IDX_W-1:0]  r_res_index, n_res_index;
    logic [WORD_W-1:0] r_res_word,  n_res_word;
    logic              r_out_valid, n_out_valid;
    logic              r_out_kind,  n_out_kind;
    logic [IDX_W-1:0]  r_out_index, n_out_index;
    logic [WORD_W-1:0] r_out_word,  n_out_word;

    logic              w_accept;
    logic              w_in_range;
    logic              w_last_addr;
    logic [CH_W-1:0]   w_alpha;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_in_range  = {1'b0, i_entry_index} < (IDX_W + 1)'(PALETTE_ENTRIES);
    assign w_last_addr = (r_addr == AW'(PALETTE_ENTRIES - 1));
    assign w_alpha     = ({1'b0, i_entry_index} == (IDX_W + 1)'(PALETTE_ENTRIES - 1))
                         ? ALPHA_CLEAR : ALPHA_OPAQUE;

    assign o_ram_we    = w_accept && (i_cmd == CMD_LOAD) && w_in_range;
    assign o_ram_re    = (r_state == ST_SCAN);
    assign o_ram_addr  = (r_state == ST_SCAN) ? r_addr : i_entry_index[AW-1:0];
    assign o_ram_wdata = {i_blue, i_green, i_red};

    assign o_tag.valid = (r_state == ST_SCAN);
    assign o_tag.last  = w_last_addr;
    assign o_tag.idx   = IDX_W'(r_addr);
    assign o_tr        = r_tr;
    assign o_tg        = r_tg;
    assign o_tb        = r_tb;

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_index = r_out_index;
    assign o_out_word  = r_out_word;

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_tr        = r_tr;
        n_tg        = r_tg;
        n_tb        = r_tb;
        n_best_dist = r_best_dist;
        n_best_idx  = r_best_idx;
        n_res_kind  = r_res_kind;
        n_res_index = r_res_index;
        n_res_word  = r_res_word;
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_index = r_out_index;
        n_out_word  = r_out_word;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        // The first entry always seeds the running minimum; a tie keeps the earlier index.
        if (i_dist.valid) begin
            if ((i_dist.idx == '0) || (i_dist.distance < r_best_dist)) begin
                n_best_dist = i_dist.distance;
                n_best_idx  = i_dist.idx;
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_cmd == CMD_LOAD) begin
                        n_res_kind  = CMD_LOAD;
                        n_res_index = '0;
                        n_res_word  = {w_alpha, i_blue, i_green, i_red};
                        n_state     = ST_DONE;
                    end else begin
                        n_tr    = expand5(i_color15[C5_W-1:0]);
                        n_tg    = expand5(i_color15[2*C5_W-1:C5_W]);
                        n_tb    = expand5(i_color15[3*C5_W-1:2*C5_W]);
                        n_addr  = '0;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                n_addr = r_addr + AW'(1);
                if (w_last_addr) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_dist.valid && i_dist.last) begin
                    n_res_kind  = CMD_LOOKUP;
                    n_res_index = n_best_idx;
                    n_res_word  = '0;
                    n_state     = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_res_kind;
                    n_out_index = r_res_index;
                    n_out_word  = r_res_word;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_addr      <= n_addr;
        r_tr        <= n_tr;
        r_tg        <= n_tg;
        r_tb        <= n_tb;
        r_best_dist <= n_best_dist;
        r_best_idx  <= n_best_idx;
        r_res_kind  <= n_res_kind;
        r_res_index <= n_res_index;
        r_res_word  <= n_res_word;
        r_out_kind  <= n_out_kind;
        r_out_index <= n_out_index;
        r_out_word  <= n_out_word;
    end

endmodule

/* design/nearest_palette_color_lookup_top.sv */
// Nearest palette color lookup: a palette RAM searched by a shared distance unit.
// Top level over nplc_pkg, nplc_ram, nplc_dist and nplc_seq.
//
// Usage: the slave channel takes command words. tuser selects the kind: 0 loads one
// palette entry (entry_index, red, green, blue), 1 looks up a 15-bit color. Every word
// returns exactly one result word on the master channel; tuser there repeats the kind.
// A load returns the entry packed as alpha, blue, green, red (alpha 0 for the last
// entry, 255 otherwise) and index 0. A lookup returns the index of the closest entry
// by squared RGB distance, the lowest index on a tie, and packed word 0.
// All entries must be loaded before the first lookup.
// A load passes its result through the result register into the output register; a
// lookup is paced by the palette sweep that reads one entry per cycle
// through the single RAM port into the distance pipeline.
// The block takes one word at a time: s_axis_tready is high only while no word is in
// work, so a new word is taken only once the last result is in the output register.
// A finished result sits in the output register, and the next word may be taken
// while it waits; if the receiver stalls, the next result waits inside the block.
// Reset (i_rst_n low, synchronous) empties the pipeline and the output; the palette
// contents are not cleared.
module nearest_palette_color_lookup_top #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // entry_index[7:0], red[15:8], green[23:16], blue[31:24], color15[46:32], zero[47]
    input  logic [nplc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // command[0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // nearest_index[7:0], packed_word[39:8]
    output logic [nplc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // result_kind[0]
    output logic                                m_axis_tuser
);
    import nplc_pkg::*;

    localparam int AW = $clog2(PALETTE_ENTRIES);

    logic              w_ram_we;
    logic              w_ram_re;
    logic [AW-1:0]     w_ram_addr;
    logic [RGB_W-1:0]  w_ram_wdata;
    logic [RGB_W-1:0]  w_ram_rdata;
    t_tag              w_tag;
    t_dist             w_dist;
    logic [CH_W-1:0]   w_tr;
    logic [CH_W-1:0]   w_tg;
    logic [CH_W-1:0]   w_tb;
    logic [IDX_W-1:0]  w_out_index;
    logic [WORD_W-1:0] w_out_word;

    nplc_ram #(
        .WIDTH (RGB_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_re    (w_ram_re),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    nplc_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (w_tag),
        .i_entry (w_ram_rdata),
        .i_tr    (w_tr),
        .i_tg    (w_tg),
        .i_tb    (w_tb),
        .o_res   (w_dist)
    );

    nplc_seq #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_cmd         (s_axis_tuser),
        .i_entry_index (s_axis_tdata[7:0]),
        .i_red         (s_axis_tdata[15:8]),
        .i_green       (s_axis_tdata[23:16]),
        .i_blue        (s_axis_tdata[31:24]),
        .i_color15     (s_axis_tdata[46:32]),
        .o_ram_we      (w_ram_we),
        .o_ram_re      (w_ram_re),
        .o_ram_addr    (w_ram_addr),
        .o_ram_wdata   (w_ram_wdata),
        .o_tag         (w_tag),
        .o_tr          (w_tr),
        .o_tg          (w_tg),
        .o_tb          (w_tb),
        .i_dist        (w_dist),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_kind    (m_axis_tuser),
        .o_out_index   (w_out_index),
        .o_out_word    (w_out_word)
    );

    assign m_axis_tdata = {w_out_word, w_out_index};

    // No new word may enter while distances are still coming out of the pipeline.
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dist.valid |-> !s_axis_tready)
        else $error("word accepted during a palette sweep");

    // A lookup answer always names an existing palette entry.
    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == CMD_LOOKUP)
            |-> ({1'b0, m_axis_tdata[7:0]} < (IDX_W + 1)'(PALETTE_ENTRIES)))
        else $error("lookup result index beyond palette");

    // Loads carry index zero, lookups carry packed word zero.
    a_unused_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tuser == CMD_LOAD) ? (m_axis_tdata[7:0] == '0)
                                                      : (m_axis_tdata[39:8] == '0)))
        else $error("unused result field not zero");

    // The palette is never written while it is being swept.
    a_no_write_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_re |-> !w_ram_we)
        else $error("palette write during sweep");

endmodule
